>>> design/rvx_pkg.sv
package rvx_pkg;

  // data memory geometry
  localparam int unsigned MemWords = 4096;
  localparam int unsigned MemAw    = $clog2(MemWords);

  // register file geometry
  localparam int unsigned NumRegs = 32;
  localparam int unsigned RegAw   = $clog2(NumRegs);

  localparam logic [31:0] PcStep = 32'd4;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_ADDI   = 4'd1,
    OP_SUB    = 4'd2,
    OP_LW     = 4'd3,
    OP_SW     = 4'd4,
    OP_JAL    = 4'd5,
    OP_JALR   = 4'd6,
    OP_BEQ    = 4'd7,
    OP_BNE    = 4'd8,
    OP_BLT    = 4'd9,
    OP_BGE    = 4'd10,
    OP_EBREAK = 4'd11
  } op_e;

  typedef struct packed {
    logic [3:0]       req_type;
    logic [RegAw-1:0] dest_reg;
    logic [RegAw-1:0] src1_reg;
    logic [RegAw-1:0] src2_reg;
    logic [31:0]      immediate;
  } req_t;

  typedef struct packed {
    logic [31:0]      next_pc;
    logic             branch_taken;
    logic             reg_written;
    logic [RegAw-1:0] written_index;
    logic [31:0]      written_value;
    logic             mem_fault;
    logic             halted;
  } rsp_t;

  // execute stage decisions for one instruction
  typedef struct packed {
    logic [31:0]      next_pc;
    logic             taken;
    logic             reg_we;
    logic             load;
    logic [RegAw-1:0] rd;
    logic [31:0]      wval;
    logic             mem_we;
    logic             mem_re;
    logic [MemAw-1:0] mem_addr;
    logic             fault;
    logic             halt;
  } exec_t;

endpackage

>>> design/rvx_regfile.sv
module rvx_regfile import rvx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             re_i,
  input  logic [RegAw-1:0] ra1_i,
  input  logic [RegAw-1:0] ra2_i,
  output logic [31:0]      rd1_o,
  output logic [31:0]      rd2_o,
  input  logic             we_i,
  input  logic [RegAw-1:0] wa_i,
  input  logic [31:0]      wd_i
);

  logic [31:0]        mem_q [NumRegs];
  logic [NumRegs-1:0] vld_q;
  logic [31:0]        rd1_q;
  logic [31:0]        rd2_q;

  // valid bits stand in for the reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[wa_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    if (re_i) begin
      rd1_q <= vld_q[ra1_i] ? mem_q[ra1_i] : '0;
      rd2_q <= vld_q[ra2_i] ? mem_q[ra2_i] : '0;
    end
  end

  assign rd1_o = rd1_q;
  assign rd2_o = rd2_q;

endmodule

>>> design/rvx_dmem.sv
module rvx_dmem import rvx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [MemAw-1:0] addr_i,
  input  logic [31:0]      wdata_i,
  output logic [31:0]      rdata_o,
  output logic             busy_o
);

  logic [31:0]      mem_q [MemWords];
  logic [31:0]      rdata_q;
  logic             busy_q;
  logic [MemAw-1:0] clr_cnt_q;
  logic [MemAw-1:0] clr_cnt_d;
  logic             busy_d;
  logic             wr_en;
  logic [MemAw-1:0] wr_addr;
  logic [31:0]      wr_data;

  // clearing sweep after reset, zeroing each word in turn from address zero up
  always_comb begin
    busy_d    = busy_q;
    clr_cnt_d = clr_cnt_q;
    if (busy_q) begin
      if (clr_cnt_q == MemAw'(MemWords - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign wr_en   = busy_q | we_i;
  assign wr_addr = busy_q ? clr_cnt_q : addr_i;
  assign wr_data = busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

>>> design/rvx_exec.sv
module rvx_exec import rvx_pkg::*; (
  input  req_t        req_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] pc_i,
  input  logic        halt_i,
  output exec_t       ex_o
);

  logic [31:0] add_ab;
  logic [31:0] add_ai;
  logic [31:0] sub_ab;
  logic [31:0] pc4;
  logic        addr_ok;
  logic        lt;
  exec_t       ex;

  assign add_ab  = a_i + b_i;
  assign add_ai  = a_i + req_i.immediate;
  assign sub_ab  = a_i - b_i;
  assign pc4     = pc_i + PcStep;
  assign addr_ok = add_ai < 32'(MemWords);
  assign lt      = $signed(a_i) < $signed(b_i);

  always_comb begin
    ex          = '0;
    ex.next_pc  = pc4;
    ex.mem_addr = add_ai[MemAw-1:0];
    ex.halt     = halt_i;
    if (halt_i) begin
      ex.next_pc = pc_i;
    end else begin
      unique case (op_e'(req_i.req_type))
        OP_ADD: begin
          ex.wval   = add_ab;
          ex.reg_we = 1'b1;
        end
        OP_ADDI: begin
          ex.wval   = add_ai;
          ex.reg_we = 1'b1;
        end
        OP_SUB: begin
          ex.wval   = sub_ab;
          ex.reg_we = 1'b1;
        end
        OP_LW: begin
          ex.mem_re = addr_ok;
          ex.reg_we = addr_ok;
          ex.load   = 1'b1;
          ex.fault  = !addr_ok;
        end
        OP_SW: begin
          ex.mem_we = addr_ok;
          ex.fault  = !addr_ok;
        end
        OP_JAL: begin
          ex.wval    = pc4;
          ex.reg_we  = 1'b1;
          ex.next_pc = req_i.immediate;
          ex.taken   = 1'b1;
        end
        OP_JALR: begin
          ex.wval    = pc4;
          ex.reg_we  = 1'b1;
          ex.next_pc = {add_ai[31:1], 1'b0};
          ex.taken   = 1'b1;
        end
        OP_BEQ: ex.taken = (a_i == b_i);
        OP_BNE: ex.taken = (a_i != b_i);
        OP_BLT: ex.taken = lt;
        OP_BGE: ex.taken = !lt;
        OP_EBREAK: begin
          ex.halt    = 1'b1;
          ex.next_pc = pc_i;
        end
        default: ;
      endcase
      // branch targets are absolute
      if (ex.taken && !ex.reg_we) begin
        ex.next_pc = req_i.immediate;
      end
      if (req_i.dest_reg == '0) begin
        ex.reg_we = 1'b0;
      end
      ex.load = ex.load & ex.reg_we;
      ex.rd   = ex.reg_we ? req_i.dest_reg : '0;
      ex.wval = ex.reg_we ? ex.wval : '0;
    end
  end

  assign ex_o = ex;

endmodule

>>> design/rv32i_subset_execute_unit.sv
// channel  | dir | valid / ready             | payload
// request  | in  | in_valid_i / in_ready_o   | in_data_i  (req_t)
// result   | out | out_valid_o / out_ready_i | out_data_o (rsp_t)
//
// one transaction per cycle sustained while out_ready_i stays high; a result is offered
// once its request has passed the execute stage (register file read) and the result
// stage (execute and data memory access); after reset a sweep zeroes the data memory,
// all MemWords words (4096), with in_ready_o low until the sweep ends
// a stalled result holds the execute stage, and requests wait in front of it
module rv32i_subset_execute_unit import rvx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  // execute stage
  logic        e_vld_q;
  req_t        e_req_q;
  logic        ovr1_q;
  logic        ovr2_q;
  logic [31:0] ovr1_val_q;
  logic [31:0] ovr2_val_q;

  // architectural pc and halt
  logic [31:0] pc_q;
  logic        halt_q;

  // result stage
  logic             w_vld_q;
  logic [31:0]      w_pc_q;
  logic             w_taken_q;
  logic             w_reg_we_q;
  logic             w_load_q;
  logic [RegAw-1:0] w_rd_q;
  logic [31:0]      w_val_q;
  logic             w_fault_q;
  logic             w_halt_q;

  logic        w_fire;
  logic        w_free;
  logic        e_adv;
  logic        in_fire;
  logic        mem_busy;
  logic [31:0] mem_rdata;
  logic [31:0] w_wdata;
  logic [31:0] rd1;
  logic [31:0] rd2;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic        rf_we;
  logic [RegAw-1:0] src1_next;
  logic [RegAw-1:0] src2_next;
  exec_t       ex;

  // handshake and stage advance
  assign w_fire     = w_vld_q & out_ready_i;
  assign w_free     = !w_vld_q | out_ready_i;
  assign e_adv      = e_vld_q & w_free;
  assign in_ready_o = !mem_busy & (!e_vld_q | e_adv);
  assign in_fire    = in_valid_i & in_ready_o;

  // register write lands when the result transaction completes
  assign w_wdata = w_load_q ? mem_rdata : w_val_q;
  assign rf_we   = w_fire & w_reg_we_q;

  rvx_regfile u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .re_i   (in_fire),
    .ra1_i  (in_data_i.src1_reg),
    .ra2_i  (in_data_i.src2_reg),
    .rd1_o  (rd1),
    .rd2_o  (rd2),
    .we_i   (rf_we),
    .wa_i   (w_rd_q),
    .wd_i   (w_wdata)
  );

  // operand bypass: pending write in the result stage first, then any write
  // that landed after the register file was read
  always_comb begin
    op_a = ovr1_q ? ovr1_val_q : rd1;
    op_b = ovr2_q ? ovr2_val_q : rd2;
    if (w_vld_q && w_reg_we_q && (w_rd_q == e_req_q.src1_reg)) begin
      op_a = w_wdata;
    end
    if (w_vld_q && w_reg_we_q && (w_rd_q == e_req_q.src2_reg)) begin
      op_b = w_wdata;
    end
  end

  rvx_exec u_exec (
    .req_i  (e_req_q),
    .a_i    (op_a),
    .b_i    (op_b),
    .pc_i   (pc_q),
    .halt_i (halt_q),
    .ex_o   (ex)
  );

  rvx_dmem u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (e_adv & ex.mem_we),
    .re_i    (e_adv & ex.mem_re),
    .addr_i  (ex.mem_addr),
    .wdata_i (op_b),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  // source indexes held by the execute stage after this edge
  assign src1_next = in_fire ? in_data_i.src1_reg : e_req_q.src1_reg;
  assign src2_next = in_fire ? in_data_i.src2_reg : e_req_q.src2_reg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      w_vld_q <= 1'b0;
      pc_q    <= '0;
      halt_q  <= 1'b0;
      ovr1_q  <= 1'b0;
      ovr2_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        e_vld_q <= 1'b1;
      end else if (e_adv) begin
        e_vld_q <= 1'b0;
      end
      if (e_adv) begin
        w_vld_q <= 1'b1;
        pc_q    <= ex.next_pc;
        halt_q  <= ex.halt;
      end else if (w_fire) begin
        w_vld_q <= 1'b0;
      end
      // capture writes that the registered read missed
      if (rf_we && (w_rd_q == src1_next)) begin
        ovr1_q <= 1'b1;
      end else if (in_fire) begin
        ovr1_q <= 1'b0;
      end
      if (rf_we && (w_rd_q == src2_next)) begin
        ovr2_q <= 1'b1;
      end else if (in_fire) begin
        ovr2_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e_req_q <= in_data_i;
    end
    if (rf_we && (w_rd_q == src1_next)) begin
      ovr1_val_q <= w_wdata;
    end
    if (rf_we && (w_rd_q == src2_next)) begin
      ovr2_val_q <= w_wdata;
    end
    if (e_adv) begin
      w_pc_q     <= ex.next_pc;
      w_taken_q  <= ex.taken;
      w_reg_we_q <= ex.reg_we;
      w_load_q   <= ex.load;
      w_rd_q     <= ex.rd;
      w_val_q    <= ex.wval;
      w_fault_q  <= ex.fault;
      w_halt_q   <= ex.halt;
    end
  end

  // result transaction
  assign out_valid_o = w_vld_q;
  always_comb begin
    out_data_o               = '0;
    out_data_o.next_pc       = w_pc_q;
    out_data_o.branch_taken  = w_taken_q;
    out_data_o.reg_written   = w_reg_we_q;
    out_data_o.written_index = w_rd_q;
    out_data_o.written_value = w_wdata;
    out_data_o.mem_fault     = w_fault_q;
    out_data_o.halted        = w_halt_q;
  end

endmodule

>>> sim/tb_rv32i_subset_execute_unit.sv
module tb_rv32i_subset_execute_unit;
  import rvx_pkg::*;

  // clock period 12; reset is released at a falling edge
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomItems  = 1750;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned ReportLimit  = 10;
  localparam logic [3:0]  OpUndefLo    = 4'd12;
  localparam logic [3:0]  OpUndefHi    = 4'd15;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  rv32i_subset_execute_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // architectural state kept by the testbench
  logic [31:0] arch_regs [NumRegs];
  logic [31:0] arch_mem  [MemWords];
  logic [31:0] arch_pc;
  logic        arch_halted;

  rsp_t        pending_rsp_q [$];
  int unsigned err_count;
  int unsigned cycle_count;
  // when set, neither side inserts gaps or stalls
  bit          burst_mode;

  // executes one instruction on the architectural state and returns its result
  function automatic rsp_t retire_instr(input req_t r);
    rsp_t        o;
    logic [31:0] a, b, npc, wval, addr;
    logic        wen, taken, fault;
    o     = '0;
    a     = arch_regs[r.src1_reg];
    b     = arch_regs[r.src2_reg];
    addr  = a + r.immediate;
    npc   = arch_pc + PcStep;
    wval  = '0;
    wen   = 1'b0;
    taken = 1'b0;
    fault = 1'b0;
    // a halted core holds its pc and ignores the instruction
    if (arch_halted) begin
      o.next_pc = arch_pc;
      o.halted  = 1'b1;
      return o;
    end
    case (r.req_type)
      OP_ADD:  begin wval = a + b;            wen = 1'b1; end
      OP_ADDI: begin wval = a + r.immediate;  wen = 1'b1; end
      OP_SUB:  begin wval = a - b;            wen = 1'b1; end
      OP_LW: begin
        if (addr < MemWords) begin
          wval = arch_mem[addr[MemAw-1:0]];
          wen  = 1'b1;
        end else begin
          fault = 1'b1;
        end
      end
      OP_SW: begin
        if (addr < MemWords) arch_mem[addr[MemAw-1:0]] = b;
        else fault = 1'b1;
      end
      OP_JAL: begin
        wval  = arch_pc + PcStep;
        wen   = 1'b1;
        npc   = r.immediate;
        taken = 1'b1;
      end
      // rs1 was sampled above, so rd equal to rs1 links after the read
      OP_JALR: begin
        wval  = arch_pc + PcStep;
        wen   = 1'b1;
        npc   = addr & ~32'd1;
        taken = 1'b1;
      end
      OP_BEQ:  taken = (a == b);
      OP_BNE:  taken = (a != b);
      OP_BLT:  taken = ($signed(a) <  $signed(b));
      OP_BGE:  taken = ($signed(a) >= $signed(b));
      OP_EBREAK: begin
        arch_halted = 1'b1;
        npc         = arch_pc;
      end
      default: ;  // undefined codes just step the pc
    endcase
    if (taken && r.req_type inside {OP_BEQ, OP_BNE, OP_BLT, OP_BGE}) npc = r.immediate;
    // writes to x0 are dropped and not reported
    if (wen && r.dest_reg != '0) begin
      arch_regs[r.dest_reg] = wval;
      o.reg_written   = 1'b1;
      o.written_index = r.dest_reg;
      o.written_value = wval;
    end
    arch_pc        = npc;
    o.next_pc      = npc;
    o.branch_taken = taken;
    o.mem_fault    = fault;
    o.halted       = arch_halted;
    return o;
  endfunction

  function automatic req_t pack_req(input logic [3:0] op, input int unsigned rd,
                                    input int unsigned rs1, input int unsigned rs2,
                                    input logic [31:0] imm);
    req_t r;
    r.req_type  = op;
    r.dest_reg  = rd[RegAw-1:0];
    r.src1_reg  = rs1[RegAw-1:0];
    r.src2_reg  = rs2[RegAw-1:0];
    r.immediate = imm;
    return r;
  endfunction

  // random instruction, shaped so most loads and stores land inside memory
  // and branches often compare equal registers
  function automatic req_t make_random_req();
    req_t        r;
    int unsigned pick, sel;
    logic [31:0] target;
    r.dest_reg  = RegAw'($urandom_range(0, NumRegs - 1));
    r.src1_reg  = RegAw'($urandom_range(0, NumRegs - 1));
    r.src2_reg  = RegAw'($urandom_range(0, NumRegs - 1));
    r.immediate = $urandom;
    pick        = $urandom_range(0, 99);
    if (pick < 15)      r.req_type = OP_ADDI;
    else if (pick < 25) r.req_type = OP_ADD;
    else if (pick < 32) r.req_type = OP_SUB;
    else if (pick < 47) r.req_type = OP_LW;
    else if (pick < 62) r.req_type = OP_SW;
    else if (pick < 67) r.req_type = OP_JAL;
    else if (pick < 72) r.req_type = OP_JALR;
    else if (pick < 96) r.req_type = 4'(OP_BEQ + $urandom_range(0, 3));
    else                r.req_type = 4'($urandom_range(OpUndefLo, OpUndefHi));
    if (r.req_type inside {OP_LW, OP_SW}) begin
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        // narrow window so loads hit words written earlier
        if (sel < 4) target = $urandom_range(0, 31);
        else         target = $urandom_range(0, MemWords - 1);
        r.immediate = target - arch_regs[r.src1_reg];
      end else if (sel == 8) begin
        r.immediate = MemWords - arch_regs[r.src1_reg];
      end
    end
    if (r.req_type inside {OP_BEQ, OP_BNE, OP_BLT, OP_BGE} && $urandom_range(0, 9) < 4)
      r.src2_reg = r.src1_reg;
    return r;
  endfunction

  // one request transaction, after a random gap unless burst_mode is set
  task automatic send_req(input req_t r);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rsp_q.push_back(retire_instr(r));
  endtask

  // hold requests back until every result is out, then let the pipe settle
  task automatic wait_results_out();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // result side: random stall before each transaction unless burst_mode is set
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 3);
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic report_field(input string field, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    err_count++;
    if (err_count <= ReportLimit)
      $display("mismatch %s: expected %h, got %h at cycle %0d", field, exp_v, act_v,
               cycle_count);
  endtask

  // result checker, compares every transaction with the oldest prediction
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp_q.size() == 0) begin
        report_field("unexpected result, next_pc", '0, out_data_o.next_pc);
      end else begin
        exp_rsp = pending_rsp_q.pop_front();
        if (out_data_o.next_pc !== exp_rsp.next_pc)
          report_field("next_pc", exp_rsp.next_pc, out_data_o.next_pc);
        if (out_data_o.branch_taken !== exp_rsp.branch_taken)
          report_field("branch_taken", 32'(exp_rsp.branch_taken),
                       32'(out_data_o.branch_taken));
        if (out_data_o.reg_written !== exp_rsp.reg_written)
          report_field("reg_written", 32'(exp_rsp.reg_written), 32'(out_data_o.reg_written));
        if (out_data_o.written_index !== exp_rsp.written_index)
          report_field("written_index", 32'(exp_rsp.written_index),
                       32'(out_data_o.written_index));
        if (out_data_o.written_value !== exp_rsp.written_value)
          report_field("written_value", exp_rsp.written_value, out_data_o.written_value);
        if (out_data_o.mem_fault !== exp_rsp.mem_fault)
          report_field("mem_fault", 32'(exp_rsp.mem_fault), 32'(out_data_o.mem_fault));
        if (out_data_o.halted !== exp_rsp.halted)
          report_field("halted", 32'(exp_rsp.halted), 32'(out_data_o.halted));
      end
    end
  end

  // watchdog, also covers the memory clearing sweep after reset
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_rv32i_subset_execute_unit: errors");
      $finish;
    end
  end

  // fresh state: x0 sum and a load from cleared memory
  task automatic test_reset_state();
    send_req(pack_req(OP_ADD, 1, 0, 0, 32'h0));
    send_req(pack_req(OP_LW, 2, 0, 0, 32'h0));
    wait_results_out();
  endtask

  // wrapping add and subtract, write to x0 dropped
  task automatic test_alu();
    send_req(pack_req(OP_ADDI, 1, 0, 0, 32'hFFFF_FFFF));
    send_req(pack_req(OP_ADDI, 2, 0, 0, 32'h7FFF_FFFF));
    send_req(pack_req(OP_ADD, 3, 1, 2, 32'h0));
    send_req(pack_req(OP_SUB, 4, 0, 1, 32'h0));
    send_req(pack_req(OP_ADDI, 0, 1, 0, 32'h1234_5678));
    wait_results_out();
  endtask

  // top and bottom words, out of range addresses, load into x0
  task automatic test_memory();
    send_req(pack_req(OP_ADDI, 7, 0, 0, 32'hDEAD_BEEF));
    send_req(pack_req(OP_SW, 0, 0, 7, MemWords - 1));
    send_req(pack_req(OP_SW, 0, 0, 1, 32'h0));
    send_req(pack_req(OP_LW, 8, 0, 0, MemWords - 1));
    send_req(pack_req(OP_SW, 0, 0, 7, MemWords));
    send_req(pack_req(OP_LW, 9, 0, 0, 32'hFFFF_FFFF));
    send_req(pack_req(OP_LW, 0, 0, 0, MemWords - 1));
    wait_results_out();
  endtask

  // jumps, signed branches at the extremes, an undefined code
  task automatic test_control();
    send_req(pack_req(OP_JAL, 10, 0, 0, 32'h0000_0100));
    send_req(pack_req(OP_JAL, 0, 0, 0, 32'hFFFF_FFFC));
    // link register is also the base, target is odd
    send_req(pack_req(OP_JALR, 10, 10, 0, 32'h0000_0003));
    send_req(pack_req(OP_ADDI, 5, 0, 0, 32'h8000_0000));
    send_req(pack_req(OP_BLT, 0, 5, 2, 32'h0000_0040));
    send_req(pack_req(OP_BGE, 0, 5, 2, 32'h0000_0080));
    send_req(pack_req(OP_BGE, 0, 2, 5, 32'h0000_00C0));
    send_req(pack_req(OP_BLT, 0, 2, 5, 32'h0000_0100));
    send_req(pack_req(OP_BEQ, 0, 5, 5, 32'h0000_0200));
    send_req(pack_req(OP_BNE, 0, 5, 5, 32'h0000_0300));
    send_req(pack_req(OP_BNE, 0, 5, 2, 32'hFFFF_FFF0));
    send_req(pack_req(OpUndefHi, 31, 31, 31, 32'hFFFF_FFFF));
    wait_results_out();
  endtask

  // random program in chunks, alternating gapped and back-to-back traffic
  task automatic test_random_program();
    int unsigned n;
    for (n = 0; n < RandomItems; n++) begin
      if (n % 250 == 0) burst_mode = ((n / 250) % 2 == 1);
      if (n == RandomItems / 2) wait_results_out();
      send_req(make_random_req());
    end
    burst_mode = 1'b0;
    wait_results_out();
  endtask

  // ebreak, then instructions that must be ignored
  task automatic test_halt();
    int unsigned n;
    send_req(pack_req(OP_EBREAK, 3, 4, 5, 32'h0000_0010));
    send_req(pack_req(OP_ADDI, 6, 0, 0, 32'h0000_0001));
    send_req(pack_req(OP_SW, 0, 0, 6, 32'h0000_0000));
    for (n = 0; n < 4; n++) send_req(make_random_req());
    send_req(pack_req(OP_EBREAK, 0, 0, 0, 32'h0));
  endtask

  initial begin
    int unsigned n;
    for (n = 0; n < NumRegs; n++) arch_regs[n] = '0;
    for (n = 0; n < MemWords; n++) arch_mem[n] = '0;
    arch_pc     = '0;
    arch_halted = 1'b0;
    err_count   = 0;
    cycle_count = 0;
    burst_mode  = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_alu();
    test_memory();
    test_control();
    test_random_program();
    test_halt();

    wait_results_out();
    if (pending_rsp_q.size() != 0) err_count++;
    if (err_count == 0) $display("tb_rv32i_subset_execute_unit: clean");
    else $display("tb_rv32i_subset_execute_unit: errors");
    $finish;
  end

endmodule
